>>> rtl/core/tde_pkg.sv
`default_nettype none
package tde_pkg;

   localparam int COORD_W   = 16;
   localparam int COUNT_W   = 7;
   localparam int INDEX_W   = 6;
   localparam int PROD_W    = COORD_W + COUNT_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [COUNT_W-1:0] MAX_GROUPS  = 7'd64;
   localparam logic [COUNT_W-1:0] MAX_WORKERS = 7'd64;
   localparam logic [COUNT_W-1:0] NB_NONE     = 7'h7F;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_DOMAIN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DOMAIN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GROUP_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WORKERS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPLIT_POLICY  = 3'd4;

   localparam logic CMD_GROUP  = 1'b0;
   localparam logic CMD_WORKER = 1'b1;

   localparam logic POLICY_STACKED = 1'b1;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_SRCH_DIV  = 10'b00_0000_0010,
      ST_SRCH_MULA = 10'b00_0000_0100,
      ST_SRCH_MULB = 10'b00_0000_1000,
      ST_LOC_DIV   = 10'b00_0001_0000,
      ST_CUTX_DIV  = 10'b00_0010_0000,
      ST_CUTX_MUL  = 10'b00_0100_0000,
      ST_CUTY_DIV  = 10'b00_1000_0000,
      ST_CUTY_MUL  = 10'b01_0000_0000,
      ST_DONE      = 10'b10_0000_0000
   } state_type;

endpackage
`default_nettype wire

>>> rtl/core/tile_decomposition_engine.sv
`default_nettype none
// Channel | Handshake            | Payload
// req     | req_valid/req_ready  | command, group_index, worker_index
// rsp     | rsp_valid/rsp_ready  | bounds, neighbors, grid, index_error
// csr     | csr_write_enable     | csr_index, csr_data (no wait, no read-back)
//
// One item at a time; req_ready is high only while idle.
// Grid search: each divisor candidate takes a 7-step run of the shared divider
// and a decision, then two products on the shared multiplier when it divides; up
// to 64 candidates per search. A group item needs one search and a worker item
// two (fewer with the stacked policy or a single part). Locating the tile is a
// 7-step division; each range cut a 16-step division and one multiply. An
// out-of-range item goes straight from idle to the result.
// Synchronous active-high reset loads the register reset values; a stalled
// result is held in the output registers until taken.
module tile_decomposition_engine
   import tde_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_command,
   input  wire logic [INDEX_W-1:0]       req_group_index,
   input  wire logic [INDEX_W-1:0]       req_worker_index,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [COORD_W-1:0]            rsp_x_begin,
   output logic [COORD_W-1:0]            rsp_x_end,
   output logic [COORD_W-1:0]            rsp_y_begin,
   output logic [COORD_W-1:0]            rsp_y_end,
   output logic signed [COUNT_W-1:0]     rsp_up_neighbor,
   output logic signed [COUNT_W-1:0]     rsp_down_neighbor,
   output logic signed [COUNT_W-1:0]     rsp_left_neighbor,
   output logic signed [COUNT_W-1:0]     rsp_right_neighbor,
   output logic [COUNT_W-1:0]            rsp_grid_columns,
   output logic [COUNT_W-1:0]            rsp_grid_rows,
   output logic                          rsp_index_error,
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [COORD_W-1:0]       csr_data
);

   // configuration
   logic [COORD_W-1:0] dom_w_ff, dom_h_ff;
   logic [COUNT_W-1:0] grp_cnt_ff, wrk_cnt_ff;
   logic               policy_ff;

   // sequencer and item
   state_type          state_ff, state_in;
   logic               phase_ff, phase_in;
   logic               cmd_ff, cmd_in;
   logic [INDEX_W-1:0] g_ff, g_in, w_ff, w_in;
   logic               err_ff, err_in;

   // shared divider
   logic [COORD_W-1:0] div_quo_ff, div_quo_in;
   logic [COUNT_W-1:0] div_rem_ff, div_rem_in;
   logic [COUNT_W-1:0] div_dsr_ff, div_dsr_in;
   logic [4:0]         div_cnt_ff, div_cnt_in;

   // grid search
   logic [COUNT_W-1:0] parts_ff, parts_in, cand_ff, cand_in, r_ff, r_in;
   logic [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [PROD_W-1:0]  prod_a_ff, prod_a_in;
   logic [7:0]         best_pen_ff, best_pen_in;
   logic [PROD_W-1:0]  best_bal_ff, best_bal_in;
   logic [COUNT_W-1:0] best_c_ff, best_c_in, best_r_ff, best_r_in;
   logic               found_ff, found_in;

   // location, cut and result
   logic [COUNT_W-1:0] grid_c_ff, grid_c_in, grid_r_ff, grid_r_in;
   logic [COUNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [COORD_W-1:0] base_ff, base_in;
   logic [COUNT_W-1:0] crem_ff, crem_in;
   logic [COORD_W-1:0] xb_ff, xb_in, xe_ff, xe_in, yb_ff, yb_in, ye_ff, ye_in;
   logic [COUNT_W-1:0] nb_up_ff, nb_up_in, nb_dn_ff, nb_dn_in;
   logic [COUNT_W-1:0] nb_lf_ff, nb_lf_in, nb_rt_ff, nb_rt_in;

   // combinational helpers
   logic [COUNT_W-1:0] ng, nw;
   logic [COUNT_W-1:0] partial;
   logic               div_ge;
   logic               div_start;
   logic [COORD_W-1:0] div_dividend;
   logic               div_short;
   logic [COUNT_W-1:0] div_divisor;
   logic [COORD_W-1:0] mul_a;
   logic [COUNT_W-1:0] mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic               go_search, go_loc;
   logic [COUNT_W-1:0] gs_parts, gl_cols, gl_rows;
   logic [COORD_W-1:0] gs_sx, gs_sy;
   logic [7:0]         pen;
   logic [PROD_W-1:0]  bal;
   logic [COORD_W-1:0] lo, start, span_x, span_y, new_b, new_e;
   logic [COUNT_W-1:0] cut_idx, minv, nxt_c;
   logic [INDEX_W-1:0] loc_idx;

   assign ng = (grp_cnt_ff > MAX_GROUPS) ? MAX_GROUPS : grp_cnt_ff;
   assign nw = (wrk_cnt_ff > MAX_WORKERS) ? MAX_WORKERS : wrk_cnt_ff;

   // one shared multiplier, registered at its consumer
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // one restoring divider step per cycle
   assign partial = {div_rem_ff[COUNT_W-2:0], div_quo_ff[COORD_W-1]};
   assign div_ge  = (partial >= div_dsr_ff);

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cmd_in      = cmd_ff;
      g_in        = g_ff;
      w_in        = w_ff;
      err_in      = err_ff;
      div_quo_in  = div_quo_ff;
      div_rem_in  = div_rem_ff;
      div_dsr_in  = div_dsr_ff;
      div_cnt_in  = div_cnt_ff;
      parts_in    = parts_ff;
      cand_in     = cand_ff;
      r_in        = r_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      prod_a_in   = prod_a_ff;
      best_pen_in = best_pen_ff;
      best_bal_in = best_bal_ff;
      best_c_in   = best_c_ff;
      best_r_in   = best_r_ff;
      found_in    = found_ff;
      grid_c_in   = grid_c_ff;
      grid_r_in   = grid_r_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      base_in     = base_ff;
      crem_in     = crem_ff;
      xb_in       = xb_ff;
      xe_in       = xe_ff;
      yb_in       = yb_ff;
      ye_in       = ye_ff;
      nb_up_in    = nb_up_ff;
      nb_dn_in    = nb_dn_ff;
      nb_lf_in    = nb_lf_ff;
      nb_rt_in    = nb_rt_ff;

      div_start    = 1'b0;
      div_dividend = '0;
      div_short    = 1'b0;
      div_divisor  = 7'd1;
      mul_a        = '0;
      mul_b        = '0;
      go_search    = 1'b0;
      go_loc       = 1'b0;
      gs_parts     = '0;
      gs_sx        = '0;
      gs_sy        = '0;
      gl_cols      = 7'd1;
      gl_rows      = 7'd1;
      pen          = '0;
      bal          = '0;
      lo           = '0;
      start        = '0;
      span_x       = '0;
      span_y       = '0;
      new_b        = '0;
      new_e        = '0;
      cut_idx      = '0;
      minv         = '0;
      nxt_c        = cand_ff + 7'd1;
      loc_idx      = '0;

      // advance the divider when running
      if (div_cnt_ff != 5'd0) begin
         div_rem_in = div_ge ? (partial - div_dsr_ff) : partial;
         div_quo_in = {div_quo_ff[COORD_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff - 5'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               g_in     = req_group_index;
               w_in     = req_worker_index;
               phase_in = 1'b0;
               if ((7'(req_group_index) >= ng) ||
                   ((req_command == CMD_WORKER) && (7'(req_worker_index) >= nw))) begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  err_in = 1'b0;
                  if (policy_ff == POLICY_STACKED) begin
                     go_loc  = 1'b1;
                     gl_cols = 7'd1;
                     gl_rows = ng;
                  end else begin
                     go_search = 1'b1;
                     gs_parts  = ng;
                     gs_sx     = dom_w_ff;
                     gs_sy     = dom_h_ff;
                  end
               end
            end
         end
         ST_SRCH_DIV: begin
            if (div_cnt_ff == 5'd0) begin
               if (div_rem_ff == 7'd0) begin
                  r_in     = div_quo_ff[COUNT_W-1:0];
                  state_in = ST_SRCH_MULA;
               end else begin
                  // not a divisor: next candidate
                  cand_in      = nxt_c;
                  div_start    = 1'b1;
                  div_dividend = COORD_W'(parts_ff);
                  div_short    = 1'b1;
                  div_divisor  = nxt_c;
               end
            end
         end
         ST_SRCH_MULA: begin
            mul_a     = sx_ff;
            mul_b     = r_ff;
            prod_a_in = mul_p;
            state_in  = ST_SRCH_MULB;
         end
         ST_SRCH_MULB: begin
            mul_a = sy_ff;
            mul_b = cand_ff;
            pen = ((17'(cand_ff) > 17'(sx_ff)) ? 8'(17'(cand_ff) - 17'(sx_ff)) : 8'd0)
                + ((17'(r_ff) > 17'(sy_ff)) ? 8'(17'(r_ff) - 17'(sy_ff)) : 8'd0);
            bal = (prod_a_ff > mul_p) ? (prod_a_ff - mul_p) : (mul_p - prod_a_ff);
            if (!found_ff || (pen < best_pen_ff) ||
                ((pen == best_pen_ff) && (bal < best_bal_ff))) begin
               found_in    = 1'b1;
               best_pen_in = pen;
               best_bal_in = bal;
               best_c_in   = cand_ff;
               best_r_in   = r_ff;
            end
            // the last divisor is the part count itself
            if (cand_ff == parts_ff) begin
               go_loc = 1'b1;
               if (!found_ff || (pen < best_pen_ff) ||
                   ((pen == best_pen_ff) && (bal < best_bal_ff))) begin
                  gl_cols = cand_ff;
                  gl_rows = r_ff;
               end else begin
                  gl_cols = best_c_ff;
                  gl_rows = best_r_ff;
               end
            end else begin
               cand_in      = nxt_c;
               div_start    = 1'b1;
               div_dividend = COORD_W'(parts_ff);
               div_short    = 1'b1;
               div_divisor  = nxt_c;
               state_in     = ST_SRCH_DIV;
            end
         end
         ST_LOC_DIV: begin
            if (div_cnt_ff == 5'd0) begin
               col_in = div_rem_ff;
               row_in = div_quo_ff[COUNT_W-1:0];
               if (!phase_ff) begin
                  nb_up_in = (div_quo_ff[COUNT_W-1:0] != 7'd0) ?
                             (7'(g_ff) - grid_c_ff) : NB_NONE;
                  nb_dn_in = ((div_quo_ff[COUNT_W-1:0] + 7'd1) < grid_r_ff) ?
                             (7'(g_ff) + grid_c_ff) : NB_NONE;
                  nb_lf_in = (div_rem_ff != 7'd0) ? (7'(g_ff) - 7'd1) : NB_NONE;
                  nb_rt_in = ((div_rem_ff + 7'd1) < grid_c_ff) ?
                             (7'(g_ff) + 7'd1) : NB_NONE;
               end
               div_start    = 1'b1;
               div_dividend = phase_ff ? (xe_ff - xb_ff) : dom_w_ff;
               div_divisor  = grid_c_ff;
               state_in     = ST_CUTX_DIV;
            end
         end
         ST_CUTX_DIV: begin
            if (div_cnt_ff == 5'd0) begin
               base_in  = div_quo_ff;
               crem_in  = div_rem_ff;
               state_in = ST_CUTX_MUL;
            end
         end
         ST_CUTX_MUL: begin
            cut_idx = col_ff;
            mul_a   = base_ff;
            mul_b   = cut_idx;
            lo      = phase_ff ? xb_ff : '0;
            minv    = (cut_idx < crem_ff) ? cut_idx : crem_ff;
            start   = lo + mul_p[COORD_W-1:0] + COORD_W'(minv);
            xb_in   = start;
            xe_in   = start + base_ff + COORD_W'(cut_idx < crem_ff);
            div_start    = 1'b1;
            div_dividend = phase_ff ? (ye_ff - yb_ff) : dom_h_ff;
            div_divisor  = grid_r_ff;
            state_in     = ST_CUTY_DIV;
         end
         ST_CUTY_DIV: begin
            if (div_cnt_ff == 5'd0) begin
               base_in  = div_quo_ff;
               crem_in  = div_rem_ff;
               state_in = ST_CUTY_MUL;
            end
         end
         ST_CUTY_MUL: begin
            cut_idx = row_ff;
            mul_a   = base_ff;
            mul_b   = cut_idx;
            lo      = phase_ff ? yb_ff : '0;
            minv    = (cut_idx < crem_ff) ? cut_idx : crem_ff;
            start   = lo + mul_p[COORD_W-1:0] + COORD_W'(minv);
            new_b   = start;
            new_e   = start + base_ff + COORD_W'(cut_idx < crem_ff);
            yb_in   = new_b;
            ye_in   = new_e;
            if (!phase_ff && (cmd_ff == CMD_WORKER)) begin
               // group tile known: split it among the workers
               span_x    = xe_ff - xb_ff;
               span_y    = new_e - new_b;
               phase_in  = 1'b1;
               go_search = 1'b1;
               gs_parts  = nw;
               gs_sx     = span_x;
               gs_sy     = span_y;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // launch a grid search
      if (go_search) begin
         if (gs_parts <= 7'd1) begin
            go_loc  = 1'b1;
            gl_cols = 7'd1;
            gl_rows = 7'd1;
         end else begin
            parts_in     = gs_parts;
            sx_in        = (gs_sx == '0) ? COORD_W'(1) : gs_sx;
            sy_in        = (gs_sy == '0) ? COORD_W'(1) : gs_sy;
            cand_in      = 7'd1;
            found_in     = 1'b0;
            div_start    = 1'b1;
            div_dividend = COORD_W'(gs_parts);
            div_short    = 1'b1;
            div_divisor  = 7'd1;
            state_in     = ST_SRCH_DIV;
         end
      end

      // grid settled: locate the tile in it
      if (go_loc) begin
         grid_c_in    = gl_cols;
         grid_r_in    = gl_rows;
         loc_idx      = phase_in ? w_ff : g_ff;
         if (state_ff == ST_IDLE) begin
            loc_idx = req_group_index;
         end
         div_start    = 1'b1;
         div_dividend = COORD_W'(loc_idx);
         div_short    = 1'b1;
         div_divisor  = gl_cols;
         state_in     = ST_LOC_DIV;
      end

      // load the divider
      if (div_start) begin
         div_rem_in = '0;
         div_dsr_in = div_divisor;
         if (div_short) begin
            div_quo_in = {div_dividend[COUNT_W-1:0], (COORD_W-COUNT_W)'(0)};
            div_cnt_in = 5'(COUNT_W);
         end else begin
            div_quo_in = div_dividend;
            div_cnt_in = 5'(COORD_W);
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dom_w_ff   <= COORD_W'(1);
         dom_h_ff   <= COORD_W'(1);
         grp_cnt_ff <= 7'd1;
         wrk_cnt_ff <= 7'd0;
         policy_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_DOMAIN_WIDTH:  dom_w_ff   <= csr_data;
            REG_DOMAIN_HEIGHT: dom_h_ff   <= csr_data;
            REG_GROUP_COUNT:   grp_cnt_ff <= csr_data[COUNT_W-1:0];
            REG_WORKERS:       wrk_cnt_ff <= csr_data[COUNT_W-1:0];
            REG_SPLIT_POLICY:  policy_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      cmd_ff      <= cmd_in;
      g_ff        <= g_in;
      w_ff        <= w_in;
      err_ff      <= err_in;
      div_quo_ff  <= div_quo_in;
      div_rem_ff  <= div_rem_in;
      div_dsr_ff  <= div_dsr_in;
      parts_ff    <= parts_in;
      cand_ff     <= cand_in;
      r_ff        <= r_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      prod_a_ff   <= prod_a_in;
      best_pen_ff <= best_pen_in;
      best_bal_ff <= best_bal_in;
      best_c_ff   <= best_c_in;
      best_r_ff   <= best_r_in;
      found_ff    <= found_in;
      grid_c_ff   <= grid_c_in;
      grid_r_ff   <= grid_r_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      base_ff     <= base_in;
      crem_ff     <= crem_in;
      xb_ff       <= xb_in;
      xe_ff       <= xe_in;
      yb_ff       <= yb_in;
      ye_ff       <= ye_in;
      nb_up_ff    <= nb_up_in;
      nb_dn_ff    <= nb_dn_in;
      nb_lf_ff    <= nb_lf_in;
      nb_rt_ff    <= nb_rt_in;
   end

   // result port
   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = (state_ff == ST_DONE);
   assign rsp_index_error    = err_ff;
   assign rsp_x_begin        = err_ff ? '0 : xb_ff;
   assign rsp_x_end          = err_ff ? '0 : xe_ff;
   assign rsp_y_begin        = err_ff ? '0 : yb_ff;
   assign rsp_y_end          = err_ff ? '0 : ye_ff;
   assign rsp_up_neighbor    = (err_ff || cmd_ff) ? NB_NONE : nb_up_ff;
   assign rsp_down_neighbor  = (err_ff || cmd_ff) ? NB_NONE : nb_dn_ff;
   assign rsp_left_neighbor  = (err_ff || cmd_ff) ? NB_NONE : nb_lf_ff;
   assign rsp_right_neighbor = (err_ff || cmd_ff) ? NB_NONE : nb_rt_ff;
   assign rsp_grid_columns   = err_ff ? 7'd1 : grid_c_ff;
   assign rsp_grid_rows      = err_ff ? 7'd1 : grid_r_ff;

   // checks
   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result waits");

   a_error_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_error) |-> (rsp_x_end == '0 && rsp_y_end == '0))
      else $error("error item carries bounds");

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_index_error) |->
         (rsp_x_begin <= rsp_x_end && rsp_y_begin <= rsp_y_end))
      else $error("tile end before begin");

   a_divider_idle_at_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (div_cnt_ff == 5'd0))
      else $error("divider running at result");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none
module testbench;
   import tde_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] x_begin;
      logic [COORD_W-1:0] x_end;
      logic [COORD_W-1:0] y_begin;
      logic [COORD_W-1:0] y_end;
      logic [COUNT_W-1:0] up_nb;
      logic [COUNT_W-1:0] down_nb;
      logic [COUNT_W-1:0] left_nb;
      logic [COUNT_W-1:0] right_nb;
      logic [COUNT_W-1:0] cols;
      logic [COUNT_W-1:0] rows;
      logic               index_error;
   } tile_t;

   localparam int IDLE_LIMIT = 20000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_command;
   logic [INDEX_W-1:0]   req_group_index;
   logic [INDEX_W-1:0]   req_worker_index;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [COORD_W-1:0]   rsp_x_begin, rsp_x_end, rsp_y_begin, rsp_y_end;
   logic signed [COUNT_W-1:0] rsp_up_neighbor, rsp_down_neighbor;
   logic signed [COUNT_W-1:0] rsp_left_neighbor, rsp_right_neighbor;
   logic [COUNT_W-1:0]   rsp_grid_columns, rsp_grid_rows;
   logic                 rsp_index_error;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_data;

   // shadow copy of the configuration registers
   int unsigned cfg_width, cfg_height, cfg_groups, cfg_workers, cfg_policy;

   tile_t       tile_queue[$];
   int unsigned mismatches;
   int unsigned items_sent, tiles_checked, error_tiles, worker_reqs;
   int unsigned configs_run;
   int unsigned burst_left;
   int unsigned idle_cycles;

   tile_decomposition_engine i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_group_index(req_group_index),
      .req_worker_index(req_worker_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_x_begin(rsp_x_begin), .rsp_x_end(rsp_x_end),
      .rsp_y_begin(rsp_y_begin), .rsp_y_end(rsp_y_end),
      .rsp_up_neighbor(rsp_up_neighbor), .rsp_down_neighbor(rsp_down_neighbor),
      .rsp_left_neighbor(rsp_left_neighbor), .rsp_right_neighbor(rsp_right_neighbor),
      .rsp_grid_columns(rsp_grid_columns), .rsp_grid_rows(rsp_grid_rows),
      .rsp_index_error(rsp_index_error),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Choose the grid: least overshoot, then least imbalance, first wins a tie.
   function automatic void choose_grid(input int unsigned parts, input int unsigned span_x,
                                       input int unsigned span_y, output int unsigned cols,
                                       output int unsigned rows);
      longint unsigned pen, bal, best_pen, best_bal, a, b;
      int unsigned     r;
      bit              found;
      cols = 1;
      rows = 1;
      found = 0;
      best_pen = 0;
      best_bal = 0;
      if (parts <= 1) return;
      if (span_x < 1) span_x = 1;
      if (span_y < 1) span_y = 1;
      for (int unsigned c = 1; c <= parts; c++) begin
         if (parts % c != 0) continue;
         r = parts / c;
         pen = 0;
         if (c > span_x) pen += c - span_x;
         if (r > span_y) pen += r - span_y;
         a = longint'(span_x) * r;
         b = longint'(span_y) * c;
         bal = (a > b) ? a - b : b - a;
         if (!found || pen < best_pen || (pen == best_pen && bal < best_bal)) begin
            found = 1;
            best_pen = pen;
            best_bal = bal;
            cols = c;
            rows = r;
         end
      end
   endfunction

   // Cut [lo, hi) into parts; the remainder goes to the lowest indices.
   function automatic void cut_span(input int unsigned lo, input int unsigned hi,
                                    input int unsigned parts, input int unsigned idx,
                                    output int unsigned first, output int unsigned last);
      int unsigned total, base, rem;
      total = (hi >= lo) ? hi - lo : 0;
      if (parts == 0) parts = 1;
      base = total / parts;
      rem = total % parts;
      first = lo + idx * base + ((idx < rem) ? idx : rem);
      last = first + base + ((idx < rem) ? 1 : 0);
   endfunction

   function automatic tile_t predict_tile(input logic cmd, input int unsigned g,
                                          input int unsigned w);
      tile_t       t;
      int unsigned ng, nw, gc, gr, gcol, grow, xb, xe, yb, ye;
      int unsigned wc, wr, wxb, wxe, wyb, wye;
      ng = (cfg_groups > MAX_GROUPS) ? MAX_GROUPS : cfg_groups;
      nw = (cfg_workers > MAX_WORKERS) ? MAX_WORKERS : cfg_workers;
      t.up_nb = NB_NONE;
      t.down_nb = NB_NONE;
      t.left_nb = NB_NONE;
      t.right_nb = NB_NONE;
      t.index_error = 1'b0;
      if (g >= ng || (cmd == CMD_WORKER && w >= nw)) begin
         t.x_begin = '0;
         t.x_end = '0;
         t.y_begin = '0;
         t.y_end = '0;
         t.cols = COUNT_W'(1);
         t.rows = COUNT_W'(1);
         t.index_error = 1'b1;
         return t;
      end
      if (cfg_policy == POLICY_STACKED) begin
         gc = 1;
         gr = ng;
      end else begin
         choose_grid(ng, cfg_width, cfg_height, gc, gr);
      end
      gcol = g % gc;
      grow = g / gc;
      cut_span(0, cfg_width, gc, gcol, xb, xe);
      cut_span(0, cfg_height, gr, grow, yb, ye);
      if (cmd == CMD_GROUP) begin
         if (grow > 0) t.up_nb = COUNT_W'(g - gc);
         if (grow + 1 < gr) t.down_nb = COUNT_W'(g + gc);
         if (gcol > 0) t.left_nb = COUNT_W'(g - 1);
         if (gcol + 1 < gc) t.right_nb = COUNT_W'(g + 1);
         t.cols = COUNT_W'(gc);
         t.rows = COUNT_W'(gr);
      end else begin
         choose_grid(nw, xe - xb, ye - yb, wc, wr);
         cut_span(xb, xe, wc, w % wc, wxb, wxe);
         cut_span(yb, ye, wr, w / wc, wyb, wye);
         xb = wxb;
         xe = wxe;
         yb = wyb;
         ye = wye;
         t.cols = COUNT_W'(wc);
         t.rows = COUNT_W'(wr);
      end
      t.x_begin = COORD_W'(xb);
      t.x_end = COORD_W'(xe);
      t.y_begin = COORD_W'(yb);
      t.y_end = COORD_W'(ye);
      return t;
   endfunction

   // Predict on each accepted item, check each accepted tile, watch for a hang.
   always @(posedge clock) begin
      tile_t got, want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            tile_queue.push_back(predict_tile(req_command, req_group_index,
                                              req_worker_index));
            if (req_command == CMD_WORKER) worker_reqs++;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_x_begin, rsp_x_end, rsp_y_begin, rsp_y_end, rsp_up_neighbor,
                   rsp_down_neighbor, rsp_left_neighbor, rsp_right_neighbor,
                   rsp_grid_columns, rsp_grid_rows, rsp_index_error};
            tiles_checked++;
            if (got.index_error) error_tiles++;
            if (tile_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("tb: unexpected tile %h", got);
            end else begin
               want = tile_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("tb: tile mismatch x %0d..%0d/%0d..%0d y %0d..%0d/%0d..%0d nb %0d %0d %0d %0d/%0d %0d %0d %0d grid %0dx%0d/%0dx%0d err %0b/%0b",
                        want.x_begin, want.x_end, got.x_begin, got.x_end,
                        want.y_begin, want.y_end, got.y_begin, got.y_end,
                        $signed(want.up_nb), $signed(want.down_nb),
                        $signed(want.left_nb), $signed(want.right_nb),
                        $signed(got.up_nb), $signed(got.down_nb),
                        $signed(got.left_nb), $signed(got.right_nb),
                        want.cols, want.rows, got.cols, got.rows,
                        want.index_error, got.index_error);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Receiver stalls: each window picks always-ready, coin-flip or long stalls.
   int unsigned stall_mode;
   int unsigned stall_left;
   int unsigned stall_tick;
   always @(posedge clock) begin
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 2);
      stall_tick++;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // Send one item; bursts of random length with random gaps between them.
   task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] g,
                            input logic [INDEX_W-1:0] w);
      bit taken;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_group_index <= g;
      req_worker_index <= w;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Hold the sender until every tile has come back.
   task automatic drain_tiles();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tile_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value[COORD_W-1:0];
      case (idx)
         REG_DOMAIN_WIDTH:  cfg_width = value & 16'hFFFF;
         REG_DOMAIN_HEIGHT: cfg_height = value & 16'hFFFF;
         REG_GROUP_COUNT:   cfg_groups = value & 7'h7F;
         REG_WORKERS:       cfg_workers = value & 7'h7F;
         REG_SPLIT_POLICY:  cfg_policy = value & 1;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Load a full setting, plus a write to an unused index that must be ignored.
   task automatic load_config(input int unsigned w, input int unsigned h,
                              input int unsigned g, input int unsigned wk,
                              input int unsigned pol);
      drain_tiles();
      write_reg(REG_DOMAIN_WIDTH, w);
      write_reg(REG_DOMAIN_HEIGHT, h);
      write_reg(REG_GROUP_COUNT, g);
      write_reg(REG_WORKERS, wk);
      write_reg(REG_SPLIT_POLICY, pol);
      write_reg(CSR_IDX_W'($urandom_range(5, 7)), $urandom);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      configs_run++;
   endtask

   // One random item: mostly valid indices, the rest anything the fields hold.
   task automatic send_random_item();
      int unsigned ng, nw, g, w;
      logic        cmd;
      ng = (cfg_groups > MAX_GROUPS) ? MAX_GROUPS : cfg_groups;
      nw = (cfg_workers > MAX_WORKERS) ? MAX_WORKERS : cfg_workers;
      cmd = 1'($urandom_range(0, 1));
      g = (ng > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, ng - 1)
                                                 : $urandom_range(0, 63);
      w = (nw > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, nw - 1)
                                                 : $urandom_range(0, 63);
      send_item(cmd, INDEX_W'(g), INDEX_W'(w));
   endtask

   // Reset values: one group, no workers.
   task automatic test_reset_values();
      send_item(CMD_GROUP, 0, 0);
      send_item(CMD_GROUP, 1, 0);
      send_item(CMD_WORKER, 0, 0);
      send_item(CMD_GROUP, 63, 63);
   endtask

   // Extremes of the registers and the fields.
   task automatic test_extremes();
      load_config(65535, 65535, 64, 64, 0);
      send_item(CMD_GROUP, 0, 0);
      send_item(CMD_GROUP, 63, 0);
      send_item(CMD_WORKER, 63, 63);
      send_item(CMD_WORKER, 27, 42);
      load_config(1, 1, 127, 127, 0);
      send_item(CMD_GROUP, 63, 0);
      send_item(CMD_WORKER, 5, 63);
      load_config(0, 0, 12, 6, 0);
      send_item(CMD_GROUP, 7, 0);
      send_item(CMD_WORKER, 11, 5);
      load_config(100, 7, 0, 3, 0);
      send_item(CMD_GROUP, 0, 0);
      send_item(CMD_WORKER, 0, 0);
      load_config(37, 1000, 10, 0, 0);
      send_item(CMD_WORKER, 3, 0);
      send_item(CMD_GROUP, 10, 0);
      send_item(CMD_WORKER, 9, 0);
   endtask

   // Stacked split and uneven remainders.
   task automatic test_stacked();
      load_config(50, 23, 7, 5, POLICY_STACKED);
      send_item(CMD_GROUP, 0, 0);
      send_item(CMD_GROUP, 6, 0);
      send_item(CMD_GROUP, 3, 0);
      send_item(CMD_WORKER, 2, 4);
      send_item(CMD_WORKER, 6, 5);
   endtask

   // Random settings, each followed by random items.
   task automatic test_random();
      int unsigned w, h, g, wk;
      for (int phase = 0; phase < 22; phase++) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 200);
         h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 200);
         g = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
         wk = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
         load_config(w, h, g, wk, $urandom_range(0, 1));
         repeat (48) send_random_item();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = 1'b0;
      req_group_index = '0;
      req_worker_index = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cfg_width = 1;
      cfg_height = 1;
      cfg_groups = 1;
      cfg_workers = 0;
      cfg_policy = 0;
      mismatches = 0;
      items_sent = 0;
      tiles_checked = 0;
      error_tiles = 0;
      worker_reqs = 0;
      configs_run = 0;
      burst_left = 0;
      idle_cycles = 0;
      stall_mode = 0;
      stall_left = 0;
      stall_tick = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_extremes();
      test_stacked();
      test_random();
      drain_tiles();
      repeat (50) @(posedge clock);

      $display("tb: %0d items over %0d settings, %0d worker requests, %0d index errors",
               items_sent, configs_run, worker_reqs, error_tiles);
      $display("tb: %0d tiles checked, %0d mismatches", tiles_checked, mismatches);
      if (mismatches == 0 && tile_queue.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
